// ----- hdl/lab_pkg.sv -----
`timescale 1ns / 1ps

package lab_pkg;

    // fixed point layout
    localparam int FRAC_BITS = 20;
    localparam int TEMP_W    = 24;
    localparam int FLAG_W    = 3;
    localparam int CFG_W     = 21;
    localparam int DIST_W    = 24;
    localparam int DEPTH_W   = CFG_W + 1;
    localparam int SUM_W     = TEMP_W + 2;
    localparam int DIFF_W    = TEMP_W + 1;

    // depth factor numerator, factor = num / (250 * 2^FRAC_BITS)
    localparam int NUM_W           = 28;
    localparam int NUM_LOW         = 786432;
    localparam int NUM_ONE         = 262144000;
    localparam int RAMP_SLOPE      = 997;
    localparam int RAMP_BASE       = 393216;
    localparam int DIST_SCALE      = 100;
    localparam int RAMP_W          = 18;
    localparam int RAMP_IW         = 13;
    localparam int RAMP_PW         = 20;
    localparam int NEAR_TRENCH_MAX = 41752;
    localparam int LOW_MAX         = 3932;
    localparam int RAMP_MAX        = 6553;

    // scaled depth before the divide by 250
    localparam int X_W            = NUM_W + CFG_W - FRAC_BITS;
    localparam int Y_W            = X_W - 1;
    localparam int QE_W           = CFG_W + 1;
    localparam int RECIP125_W     = 29;
    localparam longint RECIP125   = 64'd274877906;
    localparam int RECIP125_SHIFT = 35;
    localparam int DIV125         = 125;

    // mean of three by reciprocal multiply
    localparam int MAG_W        = SUM_W - 1;
    localparam int RECIP3_W     = 26;
    localparam int RECIP3       = 44739243;
    localparam int RECIP3_SHIFT = 27;

    // blend division
    localparam int PROD_W = DEPTH_W + DIFF_W;
    localparam int NMAG_W = PROD_W - 2;
    localparam int QBITS  = 26;
    localparam int DVS_W  = CFG_W + 1;
    localparam int REM_W  = DVS_W;
    localparam int HI_W   = NMAG_W - QBITS;
    localparam int FIN_W  = QBITS + 2;

    localparam int TEMP_MAX = 8388607;
    localparam int TEMP_MIN = -8388608;

    localparam int SCALE_RESET = 49388;
    localparam int OUTER_RESET = 1048576;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_ASSIM_DEPTH_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_RADIUS      = 1'b1;

    typedef struct packed {
        logic                     blend;
        logic                     zero_div;
        logic                     ovf;
        logic                     neg;
        logic signed [TEMP_W-1:0] temp;
        logic signed [TEMP_W-1:0] target;
    } lab_ctl_t;

endpackage

// ----- hdl/lab_prep.sv -----
`timescale 1ns / 1ps

module lab_prep
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [lab_pkg::TEMP_W-1:0] node_temp,
    input  logic signed [lab_pkg::TEMP_W-1:0] target_x,
    input  logic signed [lab_pkg::TEMP_W-1:0] target_y,
    input  logic signed [lab_pkg::TEMP_W-1:0] target_z,
    input  logic [lab_pkg::FLAG_W-1:0]        target_flags,
    input  logic [lab_pkg::CFG_W-1:0]         radius,
    input  logic signed [lab_pkg::DIST_W-1:0] trench_distance,
    input  logic [lab_pkg::CFG_W-1:0]         assim_depth_scale,
    input  logic [lab_pkg::CFG_W-1:0]         outer_radius,
    output logic                              out_valid,
    output lab_pkg::lab_ctl_t                 ctl,
    output logic [lab_pkg::DVS_W-1:0]         dvs,
    output logic [lab_pkg::REM_W-1:0]         rem,
    output logic [lab_pkg::QBITS-1:0]         nlow
);

    localparam int NSTG = 8;

    localparam logic [1:0] FAC_LOW  = 2'd0;
    localparam logic [1:0] FAC_RAMP = 2'd1;
    localparam logic [1:0] FAC_ONE  = 2'd2;

    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;

    localparam int M3_W   = lab_pkg::MAG_W + lab_pkg::RECIP3_W;
    localparam int M125_W = lab_pkg::Y_W + lab_pkg::RECIP125_W;
    localparam int MS_W   = lab_pkg::NUM_W + lab_pkg::CFG_W;

    logic [NSTG-1:0] vld_reg;

    // stage 1
    logic signed [lab_pkg::TEMP_W-1:0]  s1_temp_reg;
    logic signed [lab_pkg::SUM_W-1:0]   s1_sum_reg;
    logic [1:0]                         s1_cnt_reg;
    logic signed [lab_pkg::DEPTH_W-1:0] s1_depth_reg;
    logic [1:0]                         s1_fsel_reg;
    logic [lab_pkg::RAMP_W-1:0]         s1_ramp_reg;
    // stage 2
    logic signed [lab_pkg::TEMP_W-1:0]  s2_temp_reg;
    logic [lab_pkg::MAG_W-1:0]          s2_mag_reg;
    logic                               s2_neg_reg;
    logic [1:0]                         s2_cnt_reg;
    logic signed [lab_pkg::DEPTH_W-1:0] s2_depth_reg;
    logic [lab_pkg::NUM_W-1:0]          s2_num_reg;
    // stage 3
    logic signed [lab_pkg::TEMP_W-1:0]  s3_temp_reg;
    logic [lab_pkg::TEMP_W-1:0]         s3_qm_reg;
    logic                               s3_neg_reg;
    logic [1:0]                         s3_cnt_reg;
    logic signed [lab_pkg::DEPTH_W-1:0] s3_depth_reg;
    logic [lab_pkg::X_W-1:0]            s3_x_reg;
    // stage 4
    logic signed [lab_pkg::TEMP_W-1:0]  s4_temp_reg;
    logic signed [lab_pkg::TEMP_W-1:0]  s4_target_reg;
    logic [1:0]                         s4_cnt_reg;
    logic signed [lab_pkg::DEPTH_W-1:0] s4_depth_reg;
    logic [lab_pkg::Y_W-1:0]            s4_y_reg;
    logic [lab_pkg::QE_W-1:0]           s4_qe_reg;
    // stage 5
    logic signed [lab_pkg::TEMP_W-1:0]  s5_temp_reg;
    logic signed [lab_pkg::TEMP_W-1:0]  s5_target_reg;
    logic signed [lab_pkg::DIFF_W-1:0]  s5_diff_reg;
    logic [1:0]                         s5_cnt_reg;
    logic signed [lab_pkg::DEPTH_W-1:0] s5_depth_reg;
    logic [lab_pkg::CFG_W-1:0]          s5_assim_reg;
    // stage 6
    logic signed [lab_pkg::TEMP_W-1:0]  s6_temp_reg;
    logic signed [lab_pkg::TEMP_W-1:0]  s6_target_reg;
    logic signed [lab_pkg::PROD_W-1:0]  s6_prod_reg;
    logic [1:0]                         s6_cnt_reg;
    logic signed [lab_pkg::DEPTH_W-1:0] s6_depth_reg;
    logic [lab_pkg::CFG_W-1:0]          s6_assim_reg;
    // stage 7
    logic signed [lab_pkg::TEMP_W-1:0]  s7_temp_reg;
    logic signed [lab_pkg::TEMP_W-1:0]  s7_target_reg;
    logic [lab_pkg::NMAG_W-1:0]         s7_nmag_reg;
    logic                               s7_neg_reg;
    logic [1:0]                         s7_cnt_reg;
    logic signed [lab_pkg::DEPTH_W-1:0] s7_depth_reg;
    logic [lab_pkg::CFG_W-1:0]          s7_assim_reg;
    // stage 8
    lab_pkg::lab_ctl_t                  s8_ctl_reg;
    logic [lab_pkg::DVS_W-1:0]          s8_dvs_reg;
    logic [lab_pkg::REM_W-1:0]          s8_rem_reg;
    logic [lab_pkg::QBITS-1:0]          s8_nlow_reg;

    // stage 1 logic
    logic [lab_pkg::DIST_W-1:0]         dist_mag;
    logic                               near_trench;
    logic [1:0]                         fsel_next;
    logic [lab_pkg::RAMP_PW-1:0]        ramp_prod;
    logic [lab_pkg::RAMP_PW-1:0]        ramp_off;
    logic signed [lab_pkg::SUM_W-1:0]   sum_next;
    logic [1:0]                         cnt_next;
    logic signed [lab_pkg::DEPTH_W-1:0] depth_next;

    always_comb
    begin
        dist_mag = trench_distance[lab_pkg::DIST_W-1] ?
                   lab_pkg::DIST_W'(-trench_distance) : lab_pkg::DIST_W'(trench_distance);
        near_trench = (trench_distance[lab_pkg::DIST_W-1] || (trench_distance == '0)) &&
                      (dist_mag <= lab_pkg::DIST_W'(lab_pkg::NEAR_TRENCH_MAX));
        if (near_trench || (dist_mag <= lab_pkg::DIST_W'(lab_pkg::LOW_MAX)))
        begin
            fsel_next = FAC_LOW;
        end
        else if (dist_mag <= lab_pkg::DIST_W'(lab_pkg::RAMP_MAX))
        begin
            fsel_next = FAC_RAMP;
        end
        else
        begin
            fsel_next = FAC_ONE;
        end
        // only meaningful inside the ramp, where the distance fits the narrow slice
        ramp_prod = lab_pkg::RAMP_PW'(dist_mag[lab_pkg::RAMP_IW-1:0]) *
                    lab_pkg::RAMP_PW'(lab_pkg::DIST_SCALE);
        ramp_off  = ramp_prod - lab_pkg::RAMP_PW'(lab_pkg::RAMP_BASE);

        sum_next = (target_flags[0] ? lab_pkg::SUM_W'(target_x) : '0) +
                   (target_flags[1] ? lab_pkg::SUM_W'(target_y) : '0) +
                   (target_flags[2] ? lab_pkg::SUM_W'(target_z) : '0);
        cnt_next = {1'b0, target_flags[0]} + {1'b0, target_flags[1]} +
                   {1'b0, target_flags[2]};
        depth_next = $signed({1'b0, outer_radius}) - $signed({1'b0, radius});
    end

    // stage 2 logic
    logic [lab_pkg::NUM_W-1:0] num_next;
    logic [lab_pkg::NUM_W-1:0] slope_prod;
    logic [lab_pkg::SUM_W-1:0] sum_abs;

    always_comb
    begin
        slope_prod = lab_pkg::NUM_W'(s1_ramp_reg) * lab_pkg::NUM_W'(lab_pkg::RAMP_SLOPE);
        case (s1_fsel_reg)
            FAC_LOW:  num_next = lab_pkg::NUM_W'(lab_pkg::NUM_LOW);
            FAC_RAMP: num_next = lab_pkg::NUM_W'(lab_pkg::NUM_LOW) + slope_prod;
            FAC_ONE:  num_next = lab_pkg::NUM_W'(lab_pkg::NUM_ONE);
            default:  num_next = lab_pkg::NUM_W'(lab_pkg::NUM_ONE);
        endcase
        sum_abs = s1_sum_reg[lab_pkg::SUM_W-1] ? lab_pkg::SUM_W'(-s1_sum_reg) :
                                                 lab_pkg::SUM_W'(s1_sum_reg);
    end

    // stage 3 logic
    logic [MS_W-1:0]               scale_prod;
    logic [M3_W-1:0]               third_prod;
    logic [lab_pkg::TEMP_W-1:0]    qm_next;

    always_comb
    begin
        scale_prod = MS_W'(s2_num_reg) * MS_W'(assim_depth_scale);
        third_prod = M3_W'(s2_mag_reg) * M3_W'(lab_pkg::RECIP3);
        case (s2_cnt_reg)
            CNT_ONE:   qm_next = s2_mag_reg[lab_pkg::TEMP_W-1:0];
            CNT_TWO:   qm_next = s2_mag_reg[lab_pkg::TEMP_W:1];
            CNT_THREE: qm_next = third_prod[lab_pkg::RECIP3_SHIFT +: lab_pkg::TEMP_W];
            default:   qm_next = '0;
        endcase
    end

    // stage 4 logic: estimate of y / 125, low by at most one
    logic [M125_W-1:0] recip_prod;
    logic [lab_pkg::Y_W-1:0] y_next;

    always_comb
    begin
        y_next     = s3_x_reg[lab_pkg::X_W-1:1];
        recip_prod = M125_W'(y_next) * M125_W'(lab_pkg::RECIP125);
    end

    // stage 5 logic
    logic [lab_pkg::Y_W-1:0]  back_prod;
    logic [lab_pkg::Y_W-1:0]  rem125;
    logic [lab_pkg::QE_W-1:0] assim_full;

    always_comb
    begin
        back_prod  = lab_pkg::Y_W'(s4_qe_reg) * lab_pkg::Y_W'(lab_pkg::DIV125);
        rem125     = s4_y_reg - back_prod;
        assim_full = s4_qe_reg +
                     lab_pkg::QE_W'(rem125 >= lab_pkg::Y_W'(lab_pkg::DIV125));
    end

    // stage 7 logic
    logic [lab_pkg::PROD_W-1:0] prod_abs;

    always_comb
    begin
        prod_abs = s6_prod_reg[lab_pkg::PROD_W-1] ? lab_pkg::PROD_W'(-s6_prod_reg) :
                                                    lab_pkg::PROD_W'(s6_prod_reg);
    end

    // stage 8 logic
    lab_pkg::lab_ctl_t         ctl_next;
    logic [lab_pkg::DVS_W-1:0] dvs_next;
    logic [lab_pkg::HI_W-1:0]  nhi;

    always_comb
    begin
        dvs_next          = {s7_assim_reg, 1'b0};
        nhi               = s7_nmag_reg[lab_pkg::NMAG_W-1:lab_pkg::QBITS];
        ctl_next.blend    = (s7_cnt_reg != '0) &&
                            (s7_depth_reg <= $signed({1'b0, s7_assim_reg}));
        ctl_next.zero_div = (s7_assim_reg == '0);
        // quotient would not fit the divider, result saturates anyway
        ctl_next.ovf      = (lab_pkg::DVS_W'(nhi) >= dvs_next);
        ctl_next.neg      = s7_neg_reg;
        ctl_next.temp     = s7_temp_reg;
        ctl_next.target   = s7_target_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_temp_reg   <= node_temp;
            s1_sum_reg    <= sum_next;
            s1_cnt_reg    <= cnt_next;
            s1_depth_reg  <= depth_next;
            s1_fsel_reg   <= fsel_next;
            s1_ramp_reg   <= ramp_off[lab_pkg::RAMP_W-1:0];

            s2_temp_reg   <= s1_temp_reg;
            s2_mag_reg    <= sum_abs[lab_pkg::MAG_W-1:0];
            s2_neg_reg    <= s1_sum_reg[lab_pkg::SUM_W-1];
            s2_cnt_reg    <= s1_cnt_reg;
            s2_depth_reg  <= s1_depth_reg;
            s2_num_reg    <= num_next;

            s3_temp_reg   <= s2_temp_reg;
            s3_qm_reg     <= qm_next;
            s3_neg_reg    <= s2_neg_reg;
            s3_cnt_reg    <= s2_cnt_reg;
            s3_depth_reg  <= s2_depth_reg;
            s3_x_reg      <= scale_prod[lab_pkg::FRAC_BITS +: lab_pkg::X_W];

            s4_temp_reg   <= s3_temp_reg;
            s4_target_reg <= s3_neg_reg ? $signed(-s3_qm_reg) : $signed(s3_qm_reg);
            s4_cnt_reg    <= s3_cnt_reg;
            s4_depth_reg  <= s3_depth_reg;
            s4_y_reg      <= y_next;
            s4_qe_reg     <= recip_prod[lab_pkg::RECIP125_SHIFT +: lab_pkg::QE_W];

            s5_temp_reg   <= s4_temp_reg;
            s5_target_reg <= s4_target_reg;
            s5_diff_reg   <= lab_pkg::DIFF_W'(s4_temp_reg) - lab_pkg::DIFF_W'(s4_target_reg);
            s5_cnt_reg    <= s4_cnt_reg;
            s5_depth_reg  <= s4_depth_reg;
            s5_assim_reg  <= assim_full[lab_pkg::CFG_W-1:0];

            s6_temp_reg   <= s5_temp_reg;
            s6_target_reg <= s5_target_reg;
            s6_prod_reg   <= lab_pkg::PROD_W'(s5_depth_reg) * lab_pkg::PROD_W'(s5_diff_reg);
            s6_cnt_reg    <= s5_cnt_reg;
            s6_depth_reg  <= s5_depth_reg;
            s6_assim_reg  <= s5_assim_reg;

            s7_temp_reg   <= s6_temp_reg;
            s7_target_reg <= s6_target_reg;
            s7_nmag_reg   <= prod_abs[lab_pkg::NMAG_W-1:0];
            s7_neg_reg    <= s6_prod_reg[lab_pkg::PROD_W-1];
            s7_cnt_reg    <= s6_cnt_reg;
            s7_depth_reg  <= s6_depth_reg;
            s7_assim_reg  <= s6_assim_reg;

            s8_ctl_reg    <= ctl_next;
            s8_dvs_reg    <= dvs_next;
            s8_rem_reg    <= lab_pkg::REM_W'(nhi);
            s8_nlow_reg   <= s7_nmag_reg[lab_pkg::QBITS-1:0];
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign ctl       = s8_ctl_reg;
    assign dvs       = s8_dvs_reg;
    assign rem       = s8_rem_reg;
    assign nlow      = s8_nlow_reg;

endmodule

// ----- hdl/lab_div.sv -----
`timescale 1ns / 1ps

module lab_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  lab_pkg::lab_ctl_t         in_ctl,
    input  logic [lab_pkg::DVS_W-1:0] in_dvs,
    input  logic [lab_pkg::REM_W-1:0] in_rem,
    input  logic [lab_pkg::QBITS-1:0] in_nlow,
    output logic                      out_valid,
    output lab_pkg::lab_ctl_t         out_ctl,
    output logic [lab_pkg::QBITS-1:0] out_q
);

    localparam int NQ = lab_pkg::QBITS;

    logic [NQ-1:0]             vld_reg;
    lab_pkg::lab_ctl_t         ctl_reg  [NQ];
    logic [lab_pkg::DVS_W-1:0] dvs_reg  [NQ];
    logic [lab_pkg::REM_W-1:0] rem_reg  [NQ];
    logic [NQ-1:0]             nlow_reg [NQ];
    logic [NQ-1:0]             q_reg    [NQ];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NQ-2:0], in_valid};
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar i = 0; i < NQ; i++)
    begin : g_stage
        lab_pkg::lab_ctl_t         src_ctl;
        logic [lab_pkg::DVS_W-1:0] src_dvs;
        logic [lab_pkg::REM_W-1:0] src_rem;
        logic [NQ-1:0]             src_nlow;
        logic [NQ-1:0]             src_q;
        logic [lab_pkg::REM_W:0]   trial;
        logic [lab_pkg::REM_W:0]   diff;
        logic                      qbit;

        if (i == 0)
        begin : g_first
            assign src_ctl  = in_ctl;
            assign src_dvs  = in_dvs;
            assign src_rem  = in_rem;
            assign src_nlow = in_nlow;
            assign src_q    = '0;
        end
        else
        begin : g_next
            assign src_ctl  = ctl_reg[i-1];
            assign src_dvs  = dvs_reg[i-1];
            assign src_rem  = rem_reg[i-1];
            assign src_nlow = nlow_reg[i-1];
            assign src_q    = q_reg[i-1];
        end

        always_comb
        begin
            trial = {src_rem, src_nlow[NQ-1]};
            diff  = trial - {1'b0, src_dvs};
            qbit  = (trial >= {1'b0, src_dvs});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctl_reg[i]  <= src_ctl;
                dvs_reg[i]  <= src_dvs;
                rem_reg[i]  <= qbit ? diff[lab_pkg::REM_W-1:0] : trial[lab_pkg::REM_W-1:0];
                nlow_reg[i] <= {src_nlow[NQ-2:0], 1'b0};
                q_reg[i]    <= {src_q[NQ-2:0], qbit};
            end
        end
    end

    assign out_valid = vld_reg[NQ-1];
    assign out_ctl   = ctl_reg[NQ-1];
    assign out_q     = q_reg[NQ-1];

endmodule

// ----- hdl/lithosphere_assimilation_blend.sv -----
`timescale 1ns / 1ps

// Blends a mesh node temperature toward its boundary target when the node lies within the
// assimilation depth below the outer radius. One node is accepted per clock while the skid entry
// is empty, and each node gives exactly one result: eight stages that form the target, the
// assimilation depth and the depth times temperature product, a 26-stage restoring divider that
// produces one quotient bit per stage, and one output stage that saturates. A two-entry output
// (register plus skid) lets requests flow on after the sink stalls, until the skid fills. Register
// index 0 is assim_depth_scale and index 1 is outer_radius; write them only while the block is
// idle.
module lithosphere_assimilation_blend
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // node_temp, target_x, target_y, target_z, radius, trench_distance, zero pad
    input  logic [143:0]                  s_axis_tdata,
    // target_flags
    input  logic [lab_pkg::FLAG_W-1:0]    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // new_temp
    output logic [lab_pkg::TEMP_W-1:0]    m_axis_tdata,
    // was_blended
    output logic                          m_axis_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lab_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lab_pkg::CFG_W-1:0]     cfg_data
);

    localparam int FW = lab_pkg::FIN_W;
    localparam logic signed [FW-1:0] SAT_HI = FW'(lab_pkg::TEMP_MAX);
    localparam logic signed [FW-1:0] SAT_LO = FW'(lab_pkg::TEMP_MIN);

    logic [lab_pkg::CFG_W-1:0] scale_reg;
    logic [lab_pkg::CFG_W-1:0] outer_reg;

    logic en;

    logic                      prep_valid;
    lab_pkg::lab_ctl_t         prep_ctl;
    logic [lab_pkg::DVS_W-1:0] prep_dvs;
    logic [lab_pkg::REM_W-1:0] prep_rem;
    logic [lab_pkg::QBITS-1:0] prep_nlow;

    logic                      div_valid;
    lab_pkg::lab_ctl_t         div_ctl;
    logic [lab_pkg::QBITS-1:0] div_q;

    logic signed [lab_pkg::QBITS:0]    qs;
    logic signed [FW-1:0]              fsum;
    logic signed [lab_pkg::TEMP_W-1:0] fin_temp;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [lab_pkg::TEMP_W-1:0] out_temp_reg;
    logic [lab_pkg::TEMP_W-1:0] out_temp_next;
    logic                      out_blend_reg;
    logic                      out_blend_next;
    logic                      skid_valid_reg;
    logic                      skid_valid_next;
    logic [lab_pkg::TEMP_W-1:0] skid_temp_reg;
    logic [lab_pkg::TEMP_W-1:0] skid_temp_next;
    logic                      skid_blend_reg;
    logic                      skid_blend_next;
    logic                      take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= lab_pkg::CFG_W'(lab_pkg::SCALE_RESET);
            outer_reg <= lab_pkg::CFG_W'(lab_pkg::OUTER_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lab_pkg::REG_ASSIM_DEPTH_SCALE: scale_reg <= cfg_data;
                lab_pkg::REG_OUTER_RADIUS:      outer_reg <= cfg_data;
                default:                        scale_reg <= scale_reg;
            endcase
        end
    end

    // the whole pipe moves together, it only stops while the skid entry is occupied
    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    lab_prep u_prep
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (en),
        .in_valid          (s_axis_tvalid),
        .node_temp         ($signed(s_axis_tdata[23:0])),
        .target_x          ($signed(s_axis_tdata[47:24])),
        .target_y          ($signed(s_axis_tdata[71:48])),
        .target_z          ($signed(s_axis_tdata[95:72])),
        .target_flags      (s_axis_tuser),
        .radius            (s_axis_tdata[116:96]),
        .trench_distance   ($signed(s_axis_tdata[140:117])),
        .assim_depth_scale (scale_reg),
        .outer_radius      (outer_reg),
        .out_valid         (prep_valid),
        .ctl               (prep_ctl),
        .dvs               (prep_dvs),
        .rem               (prep_rem),
        .nlow              (prep_nlow)
    );

    lab_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .in_ctl    (prep_ctl),
        .in_dvs    (prep_dvs),
        .in_rem    (prep_rem),
        .in_nlow   (prep_nlow),
        .out_valid (div_valid),
        .out_ctl   (div_ctl),
        .out_q     (div_q)
    );

    // final add and saturation
    always_comb
    begin
        qs   = div_ctl.neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
        fsum = FW'(div_ctl.target) + FW'(qs);
        if (!div_ctl.blend)
        begin
            fin_temp = div_ctl.temp;
        end
        else if (div_ctl.zero_div)
        begin
            fin_temp = div_ctl.target;
        end
        else if (div_ctl.ovf)
        begin
            fin_temp = div_ctl.neg ? lab_pkg::TEMP_W'(lab_pkg::TEMP_MIN) :
                                     lab_pkg::TEMP_W'(lab_pkg::TEMP_MAX);
        end
        else if (fsum > SAT_HI)
        begin
            fin_temp = lab_pkg::TEMP_W'(lab_pkg::TEMP_MAX);
        end
        else if (fsum < SAT_LO)
        begin
            fin_temp = lab_pkg::TEMP_W'(lab_pkg::TEMP_MIN);
        end
        else
        begin
            fin_temp = fsum[lab_pkg::TEMP_W-1:0];
        end
    end

    assign take = out_valid_reg && m_axis_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_temp_next   = out_temp_reg;
        out_blend_next  = out_blend_reg;
        skid_valid_next = skid_valid_reg;
        skid_temp_next  = skid_temp_reg;
        skid_blend_next = skid_blend_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_temp_next   = skid_temp_reg;
                out_blend_next  = skid_blend_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || take)
        begin
            out_valid_next = div_valid;
            out_temp_next  = fin_temp;
            out_blend_next = div_ctl.blend;
        end
        else if (div_valid)
        begin
            // sink stalled with a request in hand, park the new one
            skid_valid_next = 1'b1;
            skid_temp_next  = fin_temp;
            skid_blend_next = div_ctl.blend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_temp_reg   <= out_temp_next;
        out_blend_reg  <= out_blend_next;
        skid_temp_reg  <= skid_temp_next;
        skid_blend_reg <= skid_blend_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_temp_reg;
    assign m_axis_tuser  = out_blend_reg;

endmodule
